### rtl/core/mbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbt_pkg;

	localparam int FEATURES = 4;
	localparam int FRAC     = 12;
	localparam int ACC_W    = 32;
	localparam int OP_W     = 21;   // shared multiplier operand width
	localparam int VAL_W    = 13;   // unsigned Q1.12 activations, features, rates
	localparam int WGT_W    = 16;

	localparam logic [VAL_W-1:0] Q_ONE = 13'd4096;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_TRAIN = 2'd1;
	localparam logic [1:0] CMD_INFER = 2'd2;

	localparam logic REG_LR_OUT    = 1'b0;
	localparam logic REG_LR_HIDDEN = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_FV_RD,
		S_FV_MUL,
		S_FV_ACC,
		S_FH,
		S_FO_MUL,
		S_FO_ACC,
		S_FP,
		S_T0,
		S_T1,
		S_T2,
		S_T3,
		S_U_RD,
		S_U_MUL,
		S_U_W,
		S_G1,
		S_G2,
		S_G3,
		S_G4,
		S_G5,
		S_V_MUL,
		S_V_W
	} mbt_state_t;

endpackage

`default_nettype wire

### rtl/core/mbt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mbt_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/mbt_sigmoid.sv
`timescale 1ns / 1ps
`default_nettype none

module mbt_sigmoid
	import mbt_pkg::*;
#(
	parameter int SIGMOID_TABLE_DEPTH = 256
) (
	input  wire logic signed [ACC_W-1:0] x,
	output logic             [VAL_W-1:0] y
);

	localparam int IW = $clog2(SIGMOID_TABLE_DEPTH);
	localparam int DW = $clog2(SIGMOID_TABLE_DEPTH + 1);

	logic [VAL_W-1:0] tbl [SIGMOID_TABLE_DEPTH];
	logic [15:0]      u;
	logic [16+DW-1:0] scaled;

	// entry k = round(4096 / (1 + e^-xk)), xk = -8 + 16k/depth
	for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_tbl
		localparam real XK    = -8.0 + (16.0 * k) / SIGMOID_TABLE_DEPTH;
		localparam real SV    = 4096.0 / (1.0 + $exp(-XK));
		localparam int  ENTRY = int'(SV);
		assign tbl[k] = VAL_W'(ENTRY);
	end

	// clamp to [-8, 8) and bias to unsigned
	always_comb begin
		if (x < -32'sd32768) begin
			u = 16'h0000;
		end else if (x > 32'sd32767) begin
			u = 16'hffff;
		end else begin
			u = x[15:0] ^ 16'h8000;
		end
		scaled = {{DW{1'b0}}, u} * {16'd0, DW'(SIGMOID_TABLE_DEPTH)};
		y = tbl[scaled[16 +: IW]];
	end

endmodule

`default_nettype wire

### rtl/core/mlp_backprop_trainer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tuser: cmd; tdata: index, value, features, target
// m_axis    out  m_axis_tvalid/tready        tdata: prediction, predicted_class
// apb       in   psel/penable/pwrite/pready  lr_out at 0x0, lr_hidden at 0x4
//
// One request at a time through a single 21x21 multiplier under the sequencer.
// Load: writes one weight, no result. Infer returns a prediction; Train returns one
// and then updates the weights of every hidden unit, one unit after another.
// Reset clears control and the weight valid bits (weights read as zero); rates go to 410/819.
// A finished result waits in the output register; only the next result stalls on it.
module mlp_backprop_trainer
	import mbt_pkg::*;
#(
	parameter int HIDDEN_UNITS        = 40,
	parameter int SIGMOID_TABLE_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [7:0] weight_index, [23:8] weight_value, [36:24] feature_0, [49:37] feature_1,
	// [62:50] feature_2, [75:63] feature_3, [88:76] target, rest zero
	input  wire logic [95:0] s_axis_tdata,
	// [1:0] cmd
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [12:0] prediction, [14:13] predicted_class, [15] zero
	output logic      [15:0] m_axis_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int UW   = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
	localparam int VAW  = UW + 2;
	localparam int VDEP = HIDDEN_UNITS * FEATURES;
	localparam int IXW  = 12;

	// ---------------- configuration ----------------
	logic [VAL_W-1:0] lr_out_q, lr_hidden_q;
	logic             cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;
	assign prdata = (paddr[2] == REG_LR_HIDDEN) ? {19'd0, lr_hidden_q} : {19'd0, lr_out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_out_q    <= 13'd410;
			lr_hidden_q <= 13'd819;
		end else if (cfg_we) begin
			if (paddr[2] == REG_LR_OUT) begin
				lr_out_q <= pwdata[VAL_W-1:0];
			end else begin
				lr_hidden_q <= pwdata[VAL_W-1:0];
			end
		end
	end

	// ---------------- request fields ----------------
	logic [7:0]       in_idx;
	logic [WGT_W-1:0] in_val;
	logic [VAL_W-1:0] in_x [FEATURES];
	logic [VAL_W-1:0] in_target;
	logic             in_acc;

	assign in_idx    = s_axis_tdata[7:0];
	assign in_val    = s_axis_tdata[23:8];
	assign in_x[0]   = s_axis_tdata[36:24];
	assign in_x[1]   = s_axis_tdata[49:37];
	assign in_x[2]   = s_axis_tdata[62:50];
	assign in_x[3]   = s_axis_tdata[75:63];
	assign in_target = s_axis_tdata[88:76];
	assign in_acc    = s_axis_tvalid & s_axis_tready;

	// ---------------- state ----------------
	mbt_state_t state_q, state_d;
	logic [UW-1:0] i_q;
	logic [1:0]    j_q;
	logic [1:0]    cmd_q;
	logic          out_valid_q;
	logic          i_last, out_free;

	logic [VAL_W-1:0]       x_q [FEATURES];
	logic [VAL_W-1:0]       target_q, p_q, h_q;
	logic signed [ACC_W-1:0] hacc_q, oacc_q;
	logic signed [OP_W-1:0] prod_q, d_q, t_q, q_q;
	logic signed [WGT_W-1:0] wn_q;
	logic [15:0]            out_data_q;

	assign i_last   = (i_q == UW'(HIDDEN_UNITS - 1));
	assign out_free = !out_valid_q || m_axis_tready;

	// ---------------- memories ----------------
	logic             v_we, v_re, w_we, w_re, h_we, h_re;
	logic [VAW-1:0]   v_waddr, v_raddr;
	logic [UW-1:0]    w_waddr, w_raddr, h_waddr, h_raddr;
	logic [WGT_W-1:0] v_wdata, w_wdata, h_wdata, v_rdata, w_rdata, h_rdata;
	logic             v_valid_q [VDEP];
	logic             w_valid_q [HIDDEN_UNITS];
	logic             v_rv_q, w_rv_q;
	logic signed [WGT_W-1:0] v_eff, w_eff;

	mbt_ram #(.WIDTH(WGT_W), .DEPTH(VDEP), .ADDR_W(VAW)) u_vram (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.re(v_re), .raddr(v_raddr), .rdata(v_rdata)
	);
	mbt_ram #(.WIDTH(WGT_W), .DEPTH(HIDDEN_UNITS), .ADDR_W(UW)) u_wram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.re(w_re), .raddr(w_raddr), .rdata(w_rdata)
	);
	mbt_ram #(.WIDTH(WGT_W), .DEPTH(HIDDEN_UNITS), .ADDR_W(UW)) u_hram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.re(h_re), .raddr(h_raddr), .rdata(h_rdata)
	);

	// never-written weights read as zero
	assign v_eff = v_rv_q ? $signed(v_rdata) : '0;
	assign w_eff = w_rv_q ? $signed(w_rdata) : '0;

	// ---------------- sigmoid ----------------
	logic signed [ACC_W-1:0] sig_in;
	logic [VAL_W-1:0]        sig_out;

	assign sig_in = (state_q == S_FP) ? oacc_q : hacc_q;

	mbt_sigmoid #(.SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)) u_sig (
		.x(sig_in), .y(sig_out)
	);

	// ---------------- shared multiplier ----------------
	logic signed [OP_W-1:0]   mul_a, mul_b;
	logic signed [2*OP_W-1:0] mul_p;
	logic signed [13:0]       err;
	logic [VAL_W-1:0]         one_m_p, one_m_h;

	assign err     = $signed({1'b0, target_q}) - $signed({1'b0, p_q});
	assign one_m_p = Q_ONE - p_q;
	assign one_m_h = Q_ONE - h_q;
	assign mul_p   = mul_a * mul_b;

	function automatic logic signed [OP_W-1:0] uext(input logic [VAL_W-1:0] v);
		uext = $signed({{(OP_W-VAL_W){1'b0}}, v});
	endfunction

	function automatic logic signed [OP_W-1:0] sext(input logic signed [WGT_W-1:0] v);
		sext = $signed({{(OP_W-WGT_W){v[WGT_W-1]}}, v});
	endfunction

	// weight + step, saturated to 16 bits
	function automatic logic signed [WGT_W-1:0] sat_add(input logic signed [WGT_W-1:0] w,
			input logic signed [OP_W-1:0] s);
		logic signed [OP_W:0] sum;
		sum = $signed({{(OP_W+1-WGT_W){w[WGT_W-1]}}, w}) + $signed({s[OP_W-1], s});
		if (sum > $signed((OP_W+1)'(32767))) begin
			sat_add = 16'sh7fff;
		end else if (sum < -$signed((OP_W+1)'(32768))) begin
			sat_add = -16'sh8000;
		end else begin
			sat_add = sum[WGT_W-1:0];
		end
	endfunction

	logic signed [WGT_W-1:0] wn, vn;
	assign wn = sat_add(w_eff, prod_q);
	assign vn = sat_add(v_eff, prod_q);

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && (s_axis_tuser == CMD_TRAIN || s_axis_tuser == CMD_INFER)) begin
					state_d = S_FV_RD;
				end
			end
			S_FV_RD:  state_d = S_FV_MUL;
			S_FV_MUL: state_d = S_FV_ACC;
			S_FV_ACC: state_d = (j_q == 2'd3) ? S_FH : S_FV_MUL;
			S_FH:     state_d = S_FO_MUL;
			S_FO_MUL: state_d = S_FO_ACC;
			S_FO_ACC: state_d = i_last ? S_FP : S_FV_RD;
			S_FP: begin
				if (out_free) begin
					state_d = (cmd_q == CMD_TRAIN) ? S_T0 : S_IDLE;
				end
			end
			S_T0:    state_d = S_T1;
			S_T1:    state_d = S_T2;
			S_T2:    state_d = S_T3;
			S_T3:    state_d = S_U_RD;
			S_U_RD:  state_d = S_U_MUL;
			S_U_MUL: state_d = S_U_W;
			S_U_W:   state_d = S_G1;
			S_G1:    state_d = S_G2;
			S_G2:    state_d = S_G3;
			S_G3:    state_d = S_G4;
			S_G4:    state_d = S_G5;
			S_G5:    state_d = S_V_MUL;
			S_V_MUL: state_d = S_V_W;
			S_V_W: begin
				if (j_q != 2'd3) begin
					state_d = S_V_MUL;
				end else begin
					state_d = i_last ? S_IDLE : S_U_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------- outputs of the sequencer ----------------
	logic [IXW-1:0] widx;
	assign widx = {4'd0, in_idx} - IXW'(VDEP);

	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		v_we = 1'b0; v_waddr = '0; v_wdata = '0;
		w_we = 1'b0; w_waddr = '0; w_wdata = '0;
		h_we = 1'b0; h_waddr = i_q; h_wdata = {3'd0, sig_out};
		v_re = 1'b0; v_raddr = {i_q, 2'd0};
		w_re = 1'b0; w_raddr = i_q;
		h_re = 1'b0; h_raddr = i_q;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_IDLE: begin
				if (in_acc && s_axis_tuser == CMD_LOAD) begin
					if ({4'd0, in_idx} < IXW'(VDEP)) begin
						v_we    = 1'b1;
						v_waddr = VAW'(in_idx);
						v_wdata = in_val;
					end else if ({4'd0, in_idx} < IXW'(VDEP + HIDDEN_UNITS)) begin
						w_we    = 1'b1;
						w_waddr = UW'(widx);
						w_wdata = in_val;
					end
				end
			end
			S_FV_RD: v_re = 1'b1;
			S_FV_MUL: begin
				mul_a = sext(v_eff);
				mul_b = uext(x_q[j_q]);
			end
			S_FV_ACC: begin
				if (j_q != 2'd3) begin
					v_re    = 1'b1;
					v_raddr = {i_q, j_q + 2'd1};
				end else begin
					w_re = 1'b1;
				end
			end
			S_FH: h_we = 1'b1;
			S_FO_MUL: begin
				mul_a = sext(w_eff);
				mul_b = uext(h_q);
			end
			S_T0: begin
				mul_a = OP_W'(err);
				mul_b = uext(p_q);
			end
			S_T1: begin
				mul_a = prod_q;
				mul_b = uext(one_m_p);
			end
			S_T2: begin
				mul_a = uext(lr_out_q);
				mul_b = prod_q;
			end
			S_U_RD: begin
				w_re = 1'b1;
				h_re = 1'b1;
			end
			S_U_MUL: begin
				mul_a = t_q;
				mul_b = uext(h_rdata[VAL_W-1:0]);
			end
			S_U_W: begin
				w_we    = 1'b1;
				w_waddr = i_q;
				w_wdata = wn;
			end
			S_G1: begin
				mul_a = d_q;
				mul_b = sext(wn_q);
			end
			S_G2: begin
				mul_a = prod_q;
				mul_b = uext(h_q);
			end
			S_G3: begin
				mul_a = prod_q;
				mul_b = uext(one_m_h);
			end
			S_G4: begin
				mul_a = uext(lr_hidden_q);
				mul_b = prod_q;
			end
			S_G5: v_re = 1'b1;
			S_V_MUL: begin
				mul_a = q_q;
				mul_b = uext(x_q[j_q]);
			end
			S_V_W: begin
				v_we    = 1'b1;
				v_waddr = {i_q, j_q};
				v_wdata = vn;
				if (j_q != 2'd3) begin
					v_re    = 1'b1;
					v_raddr = {i_q, j_q + 2'd1};
				end
			end
			default: ;
		endcase
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			out_valid_q <= 1'b0;
			v_rv_q      <= 1'b0;
			w_rv_q      <= 1'b0;
			for (int k = 0; k < VDEP; k++) v_valid_q[k] <= 1'b0;
			for (int k = 0; k < HIDDEN_UNITS; k++) w_valid_q[k] <= 1'b0;
		end else begin
			state_q <= state_d;
			if (v_we) v_valid_q[v_waddr] <= 1'b1;
			if (w_we) w_valid_q[w_waddr] <= 1'b1;
			if (v_re) v_rv_q <= v_valid_q[v_raddr];
			if (w_re) w_rv_q <= w_valid_q[w_raddr];

			if (state_q == S_FP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE, S_T3: begin
					i_q <= '0;
					j_q <= '0;
				end
				S_FV_ACC, S_V_W: j_q <= j_q + 2'd1;
				S_FO_ACC, S_G5: begin
					j_q <= '0;
					if (state_q == S_FO_ACC) i_q <= i_q + UW'(1);
				end
				default: ;
			endcase
			if (state_q == S_V_W && j_q == 2'd3) begin
				i_q <= i_q + UW'(1);
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		prod_q <= mul_p[FRAC +: OP_W];
		if (in_acc) begin
			for (int k = 0; k < FEATURES; k++) x_q[k] <= in_x[k];
			target_q <= in_target;
			cmd_q    <= s_axis_tuser;
			hacc_q   <= '0;
			oacc_q   <= '0;
		end
		case (state_q)
			S_FV_ACC: hacc_q <= hacc_q + {{(ACC_W-OP_W){prod_q[OP_W-1]}}, prod_q};
			S_FH: begin
				h_q    <= sig_out;
				hacc_q <= '0;
			end
			S_FO_ACC: oacc_q <= oacc_q + {{(ACC_W-OP_W){prod_q[OP_W-1]}}, prod_q};
			S_FP: begin
				p_q <= sig_out;
				if (out_free) begin
					out_data_q <= {1'b0,
						2'(({1'b0, sig_out, 1'b0} + 15'd2048) >> FRAC) + 2'd1, sig_out};
				end
			end
			S_T2:    d_q  <= prod_q;
			S_T3:    t_q  <= prod_q;
			S_U_MUL: h_q  <= h_rdata[VAL_W-1:0];
			S_U_W:   wn_q <= wn;
			S_G5:    q_q  <= prod_q;
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
